@@ rtl/core/radar_blip_projection_top_macros.svh @@
// Assertion macros for the radar blip projection block.
`ifndef RADAR_BLIP_PROJECTION_TOP_MACROS_SVH
`define RADAR_BLIP_PROJECTION_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radar blip projection check failed");
`define RBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radar blip projection check failed");
`else
`define RBP_ASSERT_NOW(label, ante, cons)
`define RBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/rbp_pkg.sv @@
// Shared types, constants and tables of the radar blip projection block.
package rbp_pkg;

  localparam int RBP_CORDIC_STEPS = 16;
  localparam int ATAN_COUNT = 24;
  localparam int FRAC_BITS = 12;
  localparam int EDGE_MARGIN = 20;
  localparam int DOT_HALF = 2;
  localparam int HEIGHT_STEP = 2;
  localparam int L2_W = 34;
  localparam int SQRT_STEPS = (L2_W + 2 * FRAC_BITS) / 2;
  localparam int ROOT_W = SQRT_STEPS;
  localparam int REM_W = ROOT_W + 4;
  localparam int QUOT_BITS = 10;
  localparam int MAG_W = 40;
  localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;

  localparam logic [11:0] SCREEN_WIDTH_RESET = 12'd640;
  localparam logic [15:0] RANGE_LIMIT_RESET = 16'd2048;
  localparam logic [7:0] DISC_RADIUS_RESET = 8'd64;
  localparam logic [15:0] HEIGHT_THRESHOLD_RESET = 16'd64;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_RANGE_LIMIT = 2'd1;
  localparam logic [1:0] REG_DISC_RADIUS = 2'd2;
  localparam logic [1:0] REG_HEIGHT_THRESHOLD = 2'd3;

  localparam logic [1:0] BAND_LEVEL = 2'd0;
  localparam logic [1:0] BAND_ABOVE = 2'd1;
  localparam logic [1:0] BAND_BELOW = 2'd2;

  localparam logic [31:0] ATAN_TURN32 [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [1:0] band;
    logic       is_friend;
    logic       zero_len;
  } rbp_tag_t;

  typedef struct packed {
    rbp_tag_t           tag;
    logic               clamp;
    logic [L2_W-1:0]    l2;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
  } rbp_sc_t;

  typedef struct packed {
    rbp_tag_t             tag;
    logic                 neg_x;
    logic                 neg_y;
    logic [ROOT_W-1:0]    den;
    logic [MAG_W-1:0]     rx;
    logic [MAG_W-1:0]     ry;
    logic [QUOT_BITS-1:0] qx;
    logic [QUOT_BITS-1:0] qy;
  } rbp_div_t;

endpackage

@@ rtl/core/rbp_sqrt_cordic.sv @@
// Pipelined square root of the squared length alongside the CORDIC rotation.
module rbp_sqrt_cordic #(
  parameter int CORDIC_STEPS = rbp_pkg::RBP_CORDIC_STEPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  rbp_pkg::rbp_sc_t in_word,
  output logic             out_valid,
  output rbp_pkg::rbp_sc_t out_word
);
  import rbp_pkg::*;

  localparam int ACTIVE = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
  localparam int PAIRS = L2_W / 2;

  logic    valid_q [SQRT_STEPS];
  rbp_sc_t word_q  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
    rbp_sc_t          prev;
    rbp_sc_t          nxt;
    logic             prev_valid;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign prev = in_word;
      assign prev_valid = in_valid;
    end else begin : g_rest
      assign prev = word_q[j-1];
      assign prev_valid = valid_q[j-1];
    end

    if (j < PAIRS) begin : g_pair
      assign pair = prev.l2[L2_W-1-2*j -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_in = {prev.rem[REM_W-3:0], pair};
    assign trial = {2'b00, prev.root, 2'b01};

    always_comb begin
      nxt = prev;
      if (rem_in >= trial) begin
        nxt.rem = rem_in - trial;
        nxt.root = {prev.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem = rem_in;
        nxt.root = {prev.root[ROOT_W-2:0], 1'b0};
      end
      if (j < ACTIVE) begin
        if (prev.z >= 0) begin
          nxt.x = prev.x - (prev.y >>> j);
          nxt.y = prev.y + (prev.x >>> j);
          nxt.z = prev.z - $signed({1'b0, ATAN_TURN32[j]});
        end else begin
          nxt.x = prev.x + (prev.y >>> j);
          nxt.y = prev.y - (prev.x >>> j);
          nxt.z = prev.z + $signed({1'b0, ATAN_TURN32[j]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else if (adv) begin
        valid_q[j] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_q[j] <= nxt;
      end
    end
  end

  assign out_valid = valid_q[SQRT_STEPS-1];
  assign out_word = word_q[SQRT_STEPS-1];

endmodule

@@ rtl/core/rbp_divider.sv @@
// Pipelined restoring divider for both pixel offset magnitudes.
module rbp_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  rbp_pkg::rbp_div_t in_word,
  output logic              out_valid,
  output rbp_pkg::rbp_div_t out_word
);
  import rbp_pkg::*;

  logic     valid_q [QUOT_BITS];
  rbp_div_t word_q  [QUOT_BITS];

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
    localparam int B = QUOT_BITS - 1 - j;
    rbp_div_t         prev;
    rbp_div_t         nxt;
    logic             prev_valid;
    logic [MAG_W-1:0] trial;

    if (j == 0) begin : g_first
      assign prev = in_word;
      assign prev_valid = in_valid;
    end else begin : g_rest
      assign prev = word_q[j-1];
      assign prev_valid = valid_q[j-1];
    end

    assign trial = {{(MAG_W-ROOT_W){1'b0}}, prev.den} << B;

    always_comb begin
      nxt = prev;
      if (prev.rx >= trial) begin
        nxt.rx = prev.rx - trial;
        nxt.qx[B] = 1'b1;
      end
      if (prev.ry >= trial) begin
        nxt.ry = prev.ry - trial;
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else if (adv) begin
        valid_q[j] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_q[j] <= nxt;
      end
    end
  end

  assign out_valid = valid_q[QUOT_BITS-1];
  assign out_word = word_q[QUOT_BITS-1];

endmodule

@@ rtl/core/radar_blip_projection_top.sv @@
// Radar blip projection: one target per word in, one dot position per word out.
// The block takes one word per clock while it is not stalled; each result passes
// through the 29-stage square root of the squared planar length, which runs
// beside the CORDIC stages, followed by the gain and radius multipliers and a
// 10-stage divider. A stall on the output while a result is valid freezes the
// whole pipeline and holds the input stalled.
`include "radar_blip_projection_top_macros.svh"
module radar_blip_projection_top #(
  parameter int CORDIC_STEPS = rbp_pkg::RBP_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] viewer_x,
  input  logic signed [15:0] viewer_y,
  input  logic signed [15:0] viewer_z,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] target_z,
  input  logic [15:0]        view_yaw,
  input  logic [7:0]         viewer_team,
  input  logic [7:0]         target_team,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] dot_left,
  output logic signed [10:0] dot_top,
  output logic               is_friend,
  output logic [1:0]         height_band
);
  import rbp_pkg::*;

  localparam logic [1:0] QUAD_NONE = 2'd0;
  localparam logic [1:0] QUAD_ONE = 2'd1;
  localparam logic [1:0] QUAD_TWO = 2'd2;
  localparam logic [1:0] QUAD_THREE = 2'd3;

  logic [11:0] screen_width;
  logic [15:0] range_limit;
  logic [7:0]  disc_radius;
  logic [15:0] height_threshold;
  logic [31:0] range_sq;

  logic                 adv;
  logic [ROOT_W-1:0]    range_den;
  logic [QUOT_BITS-1:0] quot_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SCREEN_WIDTH_RESET;
      range_limit <= RANGE_LIMIT_RESET;
      disc_radius <= DISC_RADIUS_RESET;
      height_threshold <= HEIGHT_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: screen_width <= cfg_data[11:0];
        REG_RANGE_LIMIT: range_limit <= cfg_data;
        REG_DISC_RADIUS: disc_radius <= cfg_data[7:0];
        REG_HEIGHT_THRESHOLD: height_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    range_sq <= range_limit * range_limit;
  end

  assign range_den = {1'b0, range_limit, 12'b0};
  assign quot_cap = {2'b00, disc_radius} + 10'd2;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Differences, squares, height band and the quarter turn.
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [17:0] dz;
  logic signed [17:0] thr;
  logic signed [33:0] sqx;
  logic signed [33:0] sqy;
  logic [15:0]        ang;
  logic [16:0]        ang_sum;
  logic signed [17:0] resid;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic [1:0]         band;

  assign dx = {target_x[15], target_x} - {viewer_x[15], viewer_x};
  assign dy = {target_y[15], target_y} - {viewer_y[15], viewer_y};
  assign dz = {{2{target_z[15]}}, target_z} - {{2{viewer_z[15]}}, viewer_z};
  assign thr = $signed({2'b00, height_threshold});
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign ang = 16'd0 - view_yaw;
  assign ang_sum = {1'b0, ang} + 17'h2000;
  assign resid = $signed({2'b00, ang}) - $signed({1'b0, ang_sum[16:14], 14'b0});
  assign x0 = {{3{dx[16]}}, dx, 12'b0};
  assign y0 = {{3{dy[16]}}, dy, 12'b0};

  always_comb begin
    case (ang_sum[15:14])
      QUAD_NONE: begin
        xr = x0;
        yr = y0;
      end
      QUAD_ONE: begin
        xr = -y0;
        yr = x0;
      end
      QUAD_TWO: begin
        xr = -x0;
        yr = -y0;
      end
      QUAD_THREE: begin
        xr = y0;
        yr = -x0;
      end
      default: begin
        xr = x0;
        yr = y0;
      end
    endcase
  end

  always_comb begin
    if (dz > thr) begin
      band = BAND_ABOVE;
    end else if (dz < -thr) begin
      band = BAND_BELOW;
    end else begin
      band = BAND_LEVEL;
    end
  end

  logic               a_valid;
  rbp_tag_t           a_tag;
  logic [32:0]        a_sqx;
  logic [32:0]        a_sqy;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [32:0] a_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag.band <= band;
      a_tag.is_friend <= (viewer_team == target_team);
      a_tag.zero_len <= 1'b0;
      a_sqx <= sqx[32:0];
      a_sqy <= sqy[32:0];
      a_x <= xr;
      a_y <= yr;
      a_z <= {resid[16:0], 16'b0};
    end
  end

  // Squared length and clamp decision.
  logic [L2_W-1:0] l2;
  logic            b_valid;
  rbp_sc_t         b_word;

  assign l2 = {1'b0, a_sqx} + {1'b0, a_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_word.tag <= '{band: a_tag.band, is_friend: a_tag.is_friend, zero_len: (l2 == '0)};
      b_word.clamp <= (l2 > {2'b00, range_sq});
      b_word.l2 <= l2;
      b_word.rem <= '0;
      b_word.root <= '0;
      b_word.x <= a_x;
      b_word.y <= a_y;
      b_word.z <= a_z;
    end
  end

  logic    c_valid;
  rbp_sc_t c_word;

  rbp_sqrt_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_sqrt_cordic (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(b_valid),
    .in_word(b_word),
    .out_valid(c_valid),
    .out_word(c_word)
  );

  // Gain removal and divisor selection.
  logic               d_valid;
  rbp_tag_t           d_tag;
  logic [ROOT_W-1:0]  d_den;
  logic signed [62:0] d_px;
  logic signed [62:0] d_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tag <= c_word.tag;
      d_den <= c_word.clamp ? c_word.root : range_den;
      d_px <= c_word.x * $signed({1'b0, GAIN_INV_Q30});
      d_py <= c_word.y * $signed({1'b0, GAIN_INV_Q30});
    end
  end

  // Scale by the radar radius.
  logic               e_valid;
  rbp_tag_t           e_tag;
  logic [ROOT_W-1:0]  e_den;
  logic signed [40:0] e_nx;
  logic signed [40:0] e_ny;
  logic signed [31:0] ux;
  logic signed [31:0] uy;

  assign ux = d_px[61:30];
  assign uy = d_py[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tag <= d_tag;
      e_den <= d_den;
      e_nx <= ux * $signed({1'b0, disc_radius});
      e_ny <= uy * $signed({1'b0, disc_radius});
    end
  end

  // Magnitudes for the divider.
  logic               f_valid;
  rbp_div_t           f_word;
  logic signed [40:0] abs_x;
  logic signed [40:0] abs_y;

  assign abs_x = e_nx[40] ? -e_nx : e_nx;
  assign abs_y = e_ny[40] ? -e_ny : e_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_word.tag <= e_tag;
      f_word.neg_x <= e_nx[40];
      f_word.neg_y <= e_ny[40];
      f_word.den <= e_den;
      f_word.rx <= abs_x[MAG_W-1:0];
      f_word.ry <= abs_y[MAG_W-1:0];
      f_word.qx <= '0;
      f_word.qy <= '0;
    end
  end

  logic     div_valid;
  rbp_div_t div_word;

  rbp_divider u_divider (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(f_valid),
    .in_word(f_word),
    .out_valid(div_valid),
    .out_word(div_word)
  );

  // Placement on the screen.
  logic signed [10:0] off_x;
  logic signed [10:0] off_y;
  logic signed [13:0] left_sum;
  logic signed [11:0] top_base;
  logic signed [11:0] top_sum;

  always_comb begin
    if (div_word.tag.zero_len) begin
      off_x = '0;
      off_y = '0;
    end else begin
      off_x = div_word.neg_x ? -$signed({1'b0, div_word.qx}) : $signed({1'b0, div_word.qx});
      off_y = div_word.neg_y ? -$signed({1'b0, div_word.qy}) : $signed({1'b0, div_word.qy});
    end
  end

  assign left_sum = $signed({2'b00, screen_width}) - $signed({6'b0, disc_radius})
                  - 14'(EDGE_MARGIN + DOT_HALF) + {{3{off_x[10]}}, off_x};
  assign top_base = $signed({4'b0, disc_radius}) + 12'(EDGE_MARGIN - DOT_HALF)
                  + {off_y[10], off_y};

  always_comb begin
    case (div_word.tag.band)
      BAND_ABOVE: top_sum = top_base - 12'(HEIGHT_STEP);
      BAND_BELOW: top_sum = top_base + 12'(HEIGHT_STEP);
      default: top_sum = top_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_left <= left_sum[12:0];
      dot_top <= top_sum[10:0];
      is_friend <= div_word.tag.is_friend;
      height_band <= div_word.tag.band;
    end
  end

  `RBP_ASSERT_NOW(a_root_covers_range, c_valid && c_word.clamp, c_word.root >= range_den)
  `RBP_ASSERT_NOW(a_quot_bound, div_valid && !div_word.tag.zero_len, div_word.qx <= quot_cap)
  `RBP_ASSERT_NEXT(a_freeze_holds, !adv, $stable(div_word) && $stable(div_valid))

endmodule
